>>> rtl/rne_pkg.sv
// Shared types, constants and digit tables for the Roman numeral encoder.
package rne_pkg;

  localparam int ValueW  = 10;
  localparam int SymbolW = 7;
  localparam int DigitW  = 4;
  localparam int LenW    = 3;
  localparam int Places  = 3;
  localparam int Slots   = 4;

  localparam logic [ValueW-1:0] ValueMax = 10'd1000;

  // ASCII letters
  localparam logic [SymbolW-1:0] CharNone = 7'h00;
  localparam logic [SymbolW-1:0] CharI    = 7'h49;
  localparam logic [SymbolW-1:0] CharV    = 7'h56;
  localparam logic [SymbolW-1:0] CharX    = 7'h58;
  localparam logic [SymbolW-1:0] CharL    = 7'h4C;
  localparam logic [SymbolW-1:0] CharC    = 7'h43;
  localparam logic [SymbolW-1:0] CharD    = 7'h44;
  localparam logic [SymbolW-1:0] CharM    = 7'h4D;

  // Place indexes
  localparam logic [1:0] PlaceOnes = 2'd0;
  localparam logic [1:0] PlaceTens = 2'd1;
  localparam logic [1:0] PlaceHund = 2'd2;

  // Letter choice within one place
  typedef enum logic [1:0] {
    SEL_UNIT,
    SEL_FIVE,
    SEL_TEN
  } sel_e;

  // Split value, after the tens digit is known
  typedef struct packed {
    logic              err;
    logic              m1000;
    logic [DigitW-1:0] hund;
    logic [DigitW-1:0] tens;
    logic [6:0]        rem;
  } digits_t;

  // Letters of each place, ready to be sent out
  typedef struct packed {
    logic                                   err;
    logic [Places-1:0][Slots-1:0][SymbolW-1:0] letters;
    logic [Places-1:0][LenW-1:0]            len;
  } pattern_t;

  // Number of letters for one decimal digit
  function automatic logic [LenW-1:0] digit_len(logic [DigitW-1:0] d);
    logic [LenW-1:0] n;
    case (d)
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Letter choice at one slot of a digit's pattern
  function automatic sel_e digit_sel(logic [DigitW-1:0] d, logic [1:0] slot);
    sel_e s;
    case (d)
      4'd4:    s = (slot == 2'd0) ? SEL_UNIT : SEL_FIVE;
      4'd5:    s = SEL_FIVE;
      4'd6:    s = (slot == 2'd0) ? SEL_FIVE : SEL_UNIT;
      4'd7:    s = (slot == 2'd0) ? SEL_FIVE : SEL_UNIT;
      4'd8:    s = (slot == 2'd0) ? SEL_FIVE : SEL_UNIT;
      4'd9:    s = (slot == 2'd0) ? SEL_UNIT : SEL_TEN;
      default: s = SEL_UNIT;
    endcase
    return s;
  endfunction

  // ASCII letter of a choice in a given place
  function automatic logic [SymbolW-1:0] place_letter(logic [1:0] p, sel_e s);
    logic [SymbolW-1:0] c;
    case (p)
      PlaceOnes: c = (s == SEL_UNIT) ? CharI : ((s == SEL_FIVE) ? CharV : CharX);
      PlaceTens: c = (s == SEL_UNIT) ? CharX : ((s == SEL_FIVE) ? CharL : CharC);
      PlaceHund: c = (s == SEL_UNIT) ? CharC : ((s == SEL_FIVE) ? CharD : CharM);
      default:   c = CharNone;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/rne_in_if.sv
// Input channel: one number to convert.
interface rne_in_if;
  logic                       valid;
  logic                       ready;
  logic [rne_pkg::ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/rne_out_if.sv
// Output channel: one Roman letter with end and error marks.
interface rne_out_if;
  logic                        valid;
  logic                        ready;
  logic [rne_pkg::SymbolW-1:0] symbol;
  logic                        last;
  logic                        range_error;

  modport source (output valid, output symbol, output last, output range_error, input ready);
  modport sink   (input valid, input symbol, input last, input range_error, output ready);
endinterface

>>> rtl/rne_divide.sv
// Three pipeline stages that split the value into hundreds, remainder and tens.
module rne_divide (
  input  logic             clk_i,
  input  logic             rst_ni,
  rne_in_if.sink           in_i,
  output logic             dig_valid_o,
  input  logic             dig_ready_i,
  output rne_pkg::digits_t dig_o
);

  logic                       vld1_q, vld2_q, vld3_q;
  logic                       rdy1, rdy2, rdy3;
  logic [rne_pkg::ValueW-1:0] v1_q;
  logic [rne_pkg::DigitW-1:0] h1_q, h2_q;
  logic                       err1_q, err2_q, m1_q, m2_q;
  logic [6:0]                 r2_q;
  rne_pkg::digits_t           dig_q;

  logic [15:0] prod1;
  logic [10:0] hx100;
  logic [10:0] diff2;
  logic [14:0] prod3;

  // Advance each stage when the one after it has room
  assign rdy3       = !vld3_q || dig_ready_i;
  assign rdy2       = !vld2_q || rdy3;
  assign rdy1       = !vld1_q || rdy2;
  assign in_i.ready = rdy1;

  // Hundreds by reciprocal: v * 41 / 4096 is exact below 1000
  assign prod1 = {6'd0, in_i.value} * 16'd41;
  // Remainder after hundreds
  assign hx100 = {7'd0, h1_q} * 11'd100;
  assign diff2 = {1'b0, v1_q} - hx100;
  // Tens by reciprocal: r * 205 / 2048 is exact below 100
  assign prod3 = {8'd0, r2_q} * 15'd205;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (rdy1) vld1_q <= in_i.valid;
      if (rdy2) vld2_q <= vld1_q;
      if (rdy3) vld3_q <= vld2_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      v1_q   <= in_i.value;
      h1_q   <= prod1[15:12];
      err1_q <= (in_i.value == '0) || (in_i.value > rne_pkg::ValueMax);
      m1_q   <= (in_i.value == rne_pkg::ValueMax);
    end
    if (rdy2) begin
      r2_q   <= diff2[6:0];
      h2_q   <= h1_q;
      err2_q <= err1_q;
      m2_q   <= m1_q;
    end
    if (rdy3) begin
      dig_q.err   <= err2_q;
      dig_q.m1000 <= m2_q;
      dig_q.hund  <= h2_q;
      dig_q.tens  <= prod3[14:11];
      dig_q.rem   <= r2_q;
    end
  end

  assign dig_valid_o = vld3_q;
  assign dig_o       = dig_q;

endmodule

>>> rtl/rne_pattern.sv
// Pipeline stage that finds the ones digit and lays out the letters of each place.
module rne_pattern (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              dig_valid_i,
  output logic              dig_ready_o,
  input  rne_pkg::digits_t  dig_i,
  output logic              pat_valid_o,
  input  logic              pat_ready_i,
  output rne_pkg::pattern_t pat_o
);

  logic              vld_q;
  rne_pkg::pattern_t pat_q, pat_d;
  logic [7:0]        tx10;
  logic [7:0]        diff;
  logic [rne_pkg::Places-1:0][rne_pkg::DigitW-1:0] digit;

  assign dig_ready_o = !vld_q || pat_ready_i;

  // Ones digit from remainder and tens
  assign tx10 = {4'd0, dig_i.tens} * 8'd10;
  assign diff = {1'b0, dig_i.rem} - tx10;

  // Letters per place, with single-letter overrides for errors and 1000
  always_comb begin
    digit[rne_pkg::PlaceOnes] = diff[3:0];
    digit[rne_pkg::PlaceTens] = dig_i.tens;
    digit[rne_pkg::PlaceHund] = dig_i.hund;
    pat_d.err = dig_i.err;
    for (int p = 0; p < rne_pkg::Places; p++) begin
      pat_d.len[p] = rne_pkg::digit_len(digit[p]);
      for (int s = 0; s < rne_pkg::Slots; s++) begin
        pat_d.letters[p][s] = rne_pkg::place_letter(2'(p),
                                rne_pkg::digit_sel(digit[p], 2'(s)));
      end
    end
    if (dig_i.err || dig_i.m1000) begin
      pat_d.len = '0;
      pat_d.len[rne_pkg::PlaceHund] = 3'd1;
      pat_d.letters[rne_pkg::PlaceHund][0] = dig_i.err ? rne_pkg::CharNone : rne_pkg::CharM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (dig_ready_o) begin
      vld_q <= dig_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_ready_o) begin
      pat_q <= pat_d;
    end
  end

  assign pat_valid_o = vld_q;
  assign pat_o       = pat_q;

endmodule

>>> rtl/rne_serializer.sv
// Walks the letters of one number and sends one per cycle, while out_o is ready, through the output register.
module rne_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pat_valid_i,
  output logic              pat_ready_o,
  input  rne_pkg::pattern_t pat_i,
  rne_out_if.source         out_o
);

  rne_pkg::pattern_t           item_q;
  logic                        busy_q;
  logic [1:0]                  place_q;
  logic [1:0]                  slot_q;
  logic                        out_valid_q;
  logic [rne_pkg::SymbolW-1:0] symbol_q;
  logic                        last_q;
  logic                        err_q;

  logic       emit, load, slot_last, has_next, cur_last;
  logic [1:0] next_place, start_place;
  logic [2:0] slot_inc;

  // Position within the current place
  assign slot_inc  = {1'b0, slot_q} + 3'd1;
  assign slot_last = (slot_inc == item_q.len[place_q]);

  // Next lower place that has letters
  always_comb begin
    has_next   = 1'b0;
    next_place = rne_pkg::PlaceOnes;
    if (place_q == rne_pkg::PlaceHund && item_q.len[rne_pkg::PlaceTens] != '0) begin
      has_next   = 1'b1;
      next_place = rne_pkg::PlaceTens;
    end else if (place_q != rne_pkg::PlaceOnes &&
                 item_q.len[rne_pkg::PlaceOnes] != '0) begin
      has_next   = 1'b1;
      next_place = rne_pkg::PlaceOnes;
    end
  end

  // Highest place with letters in an incoming number
  always_comb begin
    if (pat_i.len[rne_pkg::PlaceHund] != '0) begin
      start_place = rne_pkg::PlaceHund;
    end else if (pat_i.len[rne_pkg::PlaceTens] != '0) begin
      start_place = rne_pkg::PlaceTens;
    end else begin
      start_place = rne_pkg::PlaceOnes;
    end
  end

  assign cur_last    = slot_last && !has_next;
  assign emit        = busy_q && (!out_valid_q || out_o.ready);
  assign pat_ready_o = !busy_q || (emit && cur_last);
  assign load        = pat_valid_i && pat_ready_o;

  // Control: busy flag, walk pointers, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      place_q     <= rne_pkg::PlaceOnes;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q  <= 1'b1;
        place_q <= start_place;
        slot_q  <= '0;
      end else if (emit) begin
        if (cur_last) begin
          busy_q <= 1'b0;
        end else if (slot_last) begin
          place_q <= next_place;
          slot_q  <= '0;
        end else begin
          slot_q <= slot_inc[1:0];
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the number and the word on offer
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= pat_i;
    end
    if (emit) begin
      symbol_q <= item_q.letters[place_q][slot_q];
      last_q   <= cur_last;
      err_q    <= item_q.err;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.symbol      = symbol_q;
  assign out_o.last        = last_q;
  assign out_o.range_error = err_q;

endmodule

>>> rtl/roman_numeral_encoder.sv
// Top level of the Roman numeral encoder: digit split, letter layout and output walk.
//
//   channel  dir  payload                          handshake
//   in_i     in   value[9:0]                       valid/ready
//   out_o    out  symbol[6:0], last, range_error   valid/ready
//
// A number sends 1 to 12 words, one per cycle while out_o is ready; the serializer
// takes the next number as the last word of the one before goes to its output register.
// From acceptance to the first word offered, a number passes through three divide stages,
// the layout stage, the serializer's number register and the output register.
// Reset clears valid bits and the walk state only.
// A stall on out_o backs up stage by stage; nothing is lost or repeated.
module roman_numeral_encoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  rne_in_if.sink    in_i,
  rne_out_if.source out_o
);

  logic              dig_valid, dig_ready;
  rne_pkg::digits_t  dig;
  logic              pat_valid, pat_ready;
  rne_pkg::pattern_t pat;

  rne_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .dig_valid_o (dig_valid),
    .dig_ready_i (dig_ready),
    .dig_o       (dig)
  );

  rne_pattern u_pattern (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dig_valid_i (dig_valid),
    .dig_ready_o (dig_ready),
    .dig_i       (dig),
    .pat_valid_o (pat_valid),
    .pat_ready_i (pat_ready),
    .pat_o       (pat)
  );

  rne_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pat_valid_i (pat_valid),
    .pat_ready_o (pat_ready),
    .pat_i       (pat),
    .out_o       (out_o)
  );

  // An error word is a lone, empty, final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.range_error) |-> (out_o.last && out_o.symbol == rne_pkg::CharNone))
    else $error("error word not a single empty final word");

  // A good word always carries a letter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.range_error) |-> (out_o.symbol != rne_pkg::CharNone))
    else $error("letter missing on good word");

  // A stalled layout stage holds its number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pat_valid && !pat_ready) |=> (pat_valid && $stable(pat)))
    else $error("layout stage changed while stalled");

  // A stalled divide stage holds its digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_valid && !dig_ready) |=> (dig_valid && $stable(dig)))
    else $error("divide stage changed while stalled");

endmodule
